>>> rtl/core/sle_pkg.sv
package sle_pkg;

	localparam int MAX_LINE = 4096;
	localparam int POS_W    = 13;
	localparam int FLEN_W   = 14;
	localparam int BYTE_W   = 8;
	localparam int IDX_W    = 3;
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);
	localparam int MAX_EV   = 4;
	localparam int EV_IDX_W = $clog2(MAX_EV);
	localparam int EV_CNT_W = $clog2(MAX_EV + 1);

	localparam logic [BYTE_W-1:0] CH_BS  = 8'h08;
	localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_SP  = 8'h20;
	localparam logic [BYTE_W-1:0] CH_DEL = 8'h7F;

	typedef enum logic [2:0] {
		EV_ECHO       = 3'd0,
		EV_STORE      = 3'd1,
		EV_LINE_CB    = 3'd2,
		EV_LINE_DONE  = 3'd3,
		EV_PROMPT     = 3'd4,
		EV_FRAME_DONE = 3'd5,
		EV_BYTE_CB    = 3'd6
	} ev_kind_t;

	typedef enum logic [IDX_W-1:0] {
		CFG_LINE_MODE = 3'd0,
		CFG_ECHO      = 3'd1,
		CFG_CALLBACK  = 3'd2,
		CFG_FRAME_LEN = 3'd3,
		CFG_END_BYTE  = 3'd4,
		CFG_LINE_CAP  = 3'd5
	} cfg_idx_t;

	typedef enum logic [2:0] {
		OP_ERASE    = 3'd0,
		OP_LINE_END = 3'd1,
		OP_ORDINARY = 3'd2,
		OP_BYTE_CB  = 3'd3,
		OP_RAW      = 3'd4
	} op_t;

	typedef struct packed {
		logic                     line_mode;
		logic                     echo_enable;
		logic                     callback_enable;
		logic signed [FLEN_W-1:0] frame_length;
		logic [BYTE_W-1:0]        frame_end_byte;
		logic [POS_W-1:0]         line_capacity;
	} cfg_t;

	// flag: empty line for OP_LINE_END, frame closed for OP_RAW.
	typedef struct packed {
		op_t               op;
		logic              echo;
		logic              cb;
		logic              flag;
		logic [BYTE_W-1:0] data;
		logic [POS_W-1:0]  pos;
	} cmd_t;

	typedef struct packed {
		ev_kind_t          kind;
		logic [BYTE_W-1:0] data;
		logic [POS_W-1:0]  pos;
	} event_t;

endpackage

>>> rtl/core/sle_front.sv
module sle_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [sle_pkg::BYTE_W-1:0]  rx_byte,
	input  sle_pkg::cfg_t               cfg,
	output logic                        cmd_valid,
	output sle_pkg::cmd_t               cmd
);
	import sle_pkg::*;

	logic [POS_W-1:0]  fill_q;
	logic [BYTE_W-1:0] prev_q;
	logic [POS_W-1:0]  cap;
	logic [POS_W-1:0]  fill0;
	logic [POS_W-1:0]  fill_inc;
	logic [POS_W-1:0]  fill_nxt;
	logic [BYTE_W-1:0] prev_nxt;
	logic              fl_pos;
	logic              fl_neg;
	logic              frame_done;

	always_comb begin
		if (cfg.line_capacity < POS_W'(2)) begin
			cap = POS_W'(2);
		end else if (cfg.line_capacity > POS_W'(MAX_LINE)) begin
			cap = POS_W'(MAX_LINE);
		end else begin
			cap = cfg.line_capacity;
		end
	end

	assign fill0    = (fill_q >= cap) ? '0 : fill_q;
	assign fill_inc = fill0 + POS_W'(1);
	assign fl_neg   = cfg.frame_length[FLEN_W-1];
	assign fl_pos   = !fl_neg && (cfg.frame_length != '0);
	assign frame_done = (fill_inc >= cap)
		|| (fl_pos && ({1'b0, fill_inc} >= FLEN_W'(cfg.frame_length)))
		|| (fl_neg && (rx_byte == cfg.frame_end_byte));

	always_comb begin
		cmd_valid = 1'b0;
		cmd       = '{op: OP_ORDINARY, echo: cfg.echo_enable, cb: cfg.callback_enable,
			flag: 1'b0, data: rx_byte, pos: fill0};
		fill_nxt  = fill0;
		prev_nxt  = prev_q;
		if (cfg.line_mode) begin
			if (((rx_byte == CH_CR) && (prev_q == CH_LF))
				|| ((rx_byte == CH_LF) && (prev_q == CH_CR))) begin
				prev_nxt = '0;
			end else if ((rx_byte == CH_DEL) || (rx_byte == CH_BS)) begin
				cmd_valid = 1'b1;
				cmd.op    = OP_ERASE;
				prev_nxt  = '0;
				if (fill0 != '0) begin
					fill_nxt = fill0 - POS_W'(1);
				end else begin
					cmd.echo = 1'b0;
				end
				cmd.pos = fill_nxt;
			end else if ((rx_byte == CH_CR) || (rx_byte == CH_LF)) begin
				cmd_valid = 1'b1;
				cmd.op    = OP_LINE_END;
				cmd.flag  = (fill0 == '0);
				prev_nxt  = rx_byte;
				fill_nxt  = '0;
			end else begin
				cmd_valid = 1'b1;
				prev_nxt  = rx_byte;
				if (fill_inc >= cap) begin
					cmd.pos  = '0;
					fill_nxt = POS_W'(1);
				end else begin
					fill_nxt = fill_inc;
				end
			end
		end else if (cfg.callback_enable) begin
			cmd_valid = 1'b1;
			if (cfg.frame_length == '0) begin
				cmd.op = OP_BYTE_CB;
			end else begin
				cmd.op   = OP_RAW;
				cmd.flag = frame_done;
				fill_nxt = frame_done ? '0 : fill_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			prev_q <= '0;
		end else if (accept) begin
			fill_q <= fill_nxt;
			prev_q <= prev_nxt;
		end
	end

endmodule

>>> rtl/core/sle_queue.sv
module sle_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  sle_pkg::cmd_t wr_cmd,
	output logic          full,
	input  logic          rd_en,
	output logic          rd_valid,
	output sle_pkg::cmd_t rd_cmd
);
	import sle_pkg::*;

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full     = (cnt_q == QCNT_W'(QDEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_cmd   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + QPTR_W'(1);
			end
			if (rd_en) begin
				rptr_q <= (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + QPTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= QCNT_W'(QDEPTH))
		else $error("queue count beyond depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && !rd_en |=> cnt_q == $past(cnt_q) + QCNT_W'(1))
		else $error("queue count missed a write");
	assert property (@(posedge clk) disable iff (!arst_n) !(rd_en && !rd_valid))
		else $error("queue read while empty");

endmodule

>>> rtl/core/sle_back.sv
module sle_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        head_valid,
	input  sle_pkg::cmd_t               head,
	output logic                        head_done,
	output logic                        empty,
	input  logic                        pop,
	output logic [2:0]                  event_kind,
	output logic [sle_pkg::BYTE_W-1:0]  byte_value,
	output logic [sle_pkg::POS_W-1:0]   position,
	output logic                        last
);
	import sle_pkg::*;

	event_t              list [MAX_EV];
	logic [EV_CNT_W-1:0] n;
	logic [EV_IDX_W-1:0] step_q;
	logic                out_valid_q;
	event_t              out_q;
	logic                last_q;
	logic                is_last;
	logic                load;
	logic                taken;
	logic [POS_W-1:0]    pos_inc;

	assign pos_inc = head.pos + POS_W'(1);

	always_comb begin
		for (int i = 0; i < MAX_EV; i++) begin
			list[i] = '{kind: EV_ECHO, data: '0, pos: '0};
		end
		n = '0;
		case (head.op)
			OP_ERASE: begin
				if (head.echo) begin
					list[0] = '{kind: EV_ECHO, data: CH_BS, pos: '0};
					list[1] = '{kind: EV_ECHO, data: CH_SP, pos: '0};
					list[2] = '{kind: EV_ECHO, data: CH_BS, pos: '0};
					n = EV_CNT_W'(3);
				end
				list[n[EV_IDX_W-1:0]] = '{kind: EV_STORE, data: '0, pos: head.pos};
				n = n + EV_CNT_W'(1);
			end
			OP_LINE_END: begin
				if (head.echo) begin
					list[n[EV_IDX_W-1:0]] = '{kind: EV_ECHO, data: CH_LF, pos: '0};
					n = n + EV_CNT_W'(1);
				end
				if (head.cb) begin
					list[n[EV_IDX_W-1:0]] = '{kind: EV_LINE_CB, data: '0, pos: head.pos};
					n = n + EV_CNT_W'(1);
				end
				if (head.flag) begin
					list[n[EV_IDX_W-1:0]] = '{kind: EV_PROMPT, data: '0, pos: '0};
					n = n + EV_CNT_W'(1);
				end else begin
					list[n[EV_IDX_W-1:0]] = '{kind: EV_STORE, data: CH_LF, pos: head.pos};
					n = n + EV_CNT_W'(1);
					list[n[EV_IDX_W-1:0]] = '{kind: EV_LINE_DONE, data: '0, pos: pos_inc};
					n = n + EV_CNT_W'(1);
				end
			end
			OP_ORDINARY: begin
				if (head.echo) begin
					list[0] = '{kind: EV_ECHO, data: head.data, pos: '0};
					n = EV_CNT_W'(1);
				end
				list[n[EV_IDX_W-1:0]] = '{kind: EV_STORE, data: head.data, pos: head.pos};
				n = n + EV_CNT_W'(1);
			end
			OP_BYTE_CB: begin
				list[0] = '{kind: EV_BYTE_CB, data: head.data, pos: POS_W'(1)};
				n = EV_CNT_W'(1);
			end
			OP_RAW: begin
				list[0] = '{kind: EV_STORE, data: head.data, pos: head.pos};
				n = EV_CNT_W'(1);
				if (head.flag) begin
					list[1] = '{kind: EV_FRAME_DONE, data: '0, pos: pos_inc};
					n = EV_CNT_W'(2);
				end
			end
			default: begin
				n = EV_CNT_W'(1);
			end
		endcase
	end

	assign is_last   = ({1'b0, step_q} + EV_CNT_W'(1)) >= n;
	assign taken     = pop && out_valid_q;
	assign load      = head_valid && (!out_valid_q || taken);
	assign head_done = load && is_last;

	always_ff @(posedge clk) begin
		if (load) begin
			out_q  <= list[step_q];
			last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				step_q      <= is_last ? '0 : step_q + EV_IDX_W'(1);
			end else if (taken) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty      = !out_valid_q;
	assign event_kind = out_q.kind;
	assign byte_value = out_q.data;
	assign position   = out_q.pos;
	assign last       = last_q;

	assert property (@(posedge clk) disable iff (!arst_n) step_q != '0 |-> head_valid)
		else $error("command left the queue before all its beats");
	assert property (@(posedge clk) disable iff (!arst_n)
		load && !is_last |=> step_q == $past(step_q) + EV_IDX_W'(1))
		else $error("beat index did not advance");
	assert property (@(posedge clk) disable iff (!arst_n) head_done |=> step_q == '0)
		else $error("beat index not rewound after final beat");

endmodule

>>> rtl/core/serial_line_editor_framer_top.sv
// Serial line editor and framer.
// Input side is a queue: drive rx_byte with push; a beat is taken at a clock
// edge with push high and full low. Result side is a queue too: while empty is
// low the oldest result sits on event_kind, byte_value, position and last, and
// a beat leaves at an edge with pop high. Each received byte yields zero to
// four results; last marks the final one of a byte.
// The front classifies a byte and updates the line position in the cycle it
// is taken, and writes a command into a four-entry queue. The back expands
// the head command into results, one per cycle while the receiver keeps
// up with pop, into an output register. The first result of a byte passes
// through its queue entry and then the output register to the result ports.
// One byte per cycle is taken while the queue has room; results leave at
// one per cycle while pop is high. When the receiver holds pop low the output
// register holds, the queue fills and full rises; bytes that give no result
// still need a free queue entry.
// Reset clears the queues, the position and the saved byte, and loads the
// registers with line mode, echo on, callback off, per-byte raw framing,
// end byte zero and a capacity of 256. Write registers through wr_en, wr_index
// and wr_data only while no byte is in flight; the block does not enforce it.
module serial_line_editor_framer_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [sle_pkg::BYTE_W-1:0]        rx_byte,
	output logic                              empty,
	input  logic                              pop,
	output logic [2:0]                        event_kind,
	output logic [sle_pkg::BYTE_W-1:0]        byte_value,
	output logic [sle_pkg::POS_W-1:0]         position,
	output logic                              last,
	input  logic                              wr_en,
	input  logic [sle_pkg::IDX_W-1:0]         wr_index,
	input  logic [sle_pkg::FLEN_W-1:0]        wr_data
);
	import sle_pkg::*;

	cfg_t cfg_q;
	logic accept;
	logic cmd_valid;
	cmd_t cmd;
	logic head_valid;
	cmd_t head;
	logic head_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{line_mode: 1'b1, echo_enable: 1'b1, callback_enable: 1'b0,
				frame_length: '0, frame_end_byte: '0, line_capacity: POS_W'(256)};
		end else if (wr_en) begin
			case (wr_index)
				CFG_LINE_MODE: cfg_q.line_mode       <= wr_data[0];
				CFG_ECHO:      cfg_q.echo_enable     <= wr_data[0];
				CFG_CALLBACK:  cfg_q.callback_enable <= wr_data[0];
				CFG_FRAME_LEN: cfg_q.frame_length    <= wr_data;
				CFG_END_BYTE:  cfg_q.frame_end_byte  <= wr_data[BYTE_W-1:0];
				CFG_LINE_CAP:  cfg_q.line_capacity   <= wr_data[POS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign accept = push && !full;

	sle_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.rx_byte   (rx_byte),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd)
	);

	sle_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (accept && cmd_valid),
		.wr_cmd   (cmd),
		.full     (full),
		.rd_en    (head_done),
		.rd_valid (head_valid),
		.rd_cmd   (head)
	);

	sle_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.head_done  (head_done),
		.empty      (empty),
		.pop        (pop),
		.event_kind (event_kind),
		.byte_value (byte_value),
		.position   (position),
		.last       (last)
	);

endmodule
